@@ rtl/g2n_pkg.sv @@
package g2n_pkg;

  localparam int FRAC = 30;
  localparam int CORDIC_STAGES = 24;
  localparam int ANGLE_TABLE_LEN = 40;
  localparam int STG_W = $clog2(ANGLE_TABLE_LEN);

  localparam int ANG_W = 32;
  localparam int ALT_W = 28;
  localparam int CW = FRAC + 3;
  localparam int ZW = 34;
  localparam int LW = 36;
  localparam int SW = LW + 2;
  localparam int ECEF_W = 34;
  localparam int NED_W = 35;

  localparam int SQRT_CELLS = FRAC + 1;
  localparam int SQ_PW = $clog2(SQRT_CELLS);
  localparam int SQ_RW = FRAC + 4;
  localparam int SQ_QW = FRAC + 2;
  localparam int SQ_VW = 2 * (FRAC + 1);

  localparam int DIV_CELLS = FRAC + 33;
  localparam int DIV_KW = $clog2(DIV_CELLS);
  localparam int DIV_RW = FRAC + 2;
  localparam int DIV_QW = FRAC + 1;
  localparam int QUO_W = 34;

  localparam int SIDE_DEPTH = SQRT_CELLS + DIV_CELLS + 4;
  localparam int GEO_LAT = CORDIC_STAGES + 3 + SQRT_CELLS + DIV_CELLS + 3;

  localparam longint GAIN_Q40 = 64'sd667681663043;
  localparam longint ECC2_Q40 = 64'sd7360548651;
  localparam longint GAIN = (GAIN_Q40 + (64'sd1 <<< (39 - FRAC))) >>> (40 - FRAC);
  localparam longint E2 = (ECC2_Q40 + (64'sd1 <<< (39 - FRAC))) >>> (40 - FRAC);
  localparam longint ONE = 64'sd1 <<< FRAC;
  localparam longint ONE_M_E2 = ONE - E2;
  localparam longint SEMI_MAJOR_MM = 64'sd6378137000;
  localparam logic [DIV_CELLS-1:0] DIVIDEND = DIV_CELLS'(SEMI_MAJOR_MM) << FRAC;

  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd2147483648);

  localparam int CFG_IW = 4;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_LAT = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_ORIGIN_LON = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_ORIGIN_ALT = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_ORIGIN_VALID = CFG_IW'(3);

  localparam int ATAN_TAB [0:ANGLE_TABLE_LEN-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } cordic_t;

  typedef struct packed {
    logic [SQ_RW-1:0] r;
    logic [SQ_QW-1:0] q;
    logic [SQ_VW-1:0] v;
  } sqrt_t;

  typedef struct packed {
    logic [DIV_RW-1:0] r;
    logic [DIV_QW-1:0] q;
    logic [QUO_W-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] sl;
    logic signed [CW-1:0] cl;
    logic signed [CW-1:0] so;
    logic signed [CW-1:0] co;
  } trig_t;

  typedef struct packed {
    trig_t                   trig;
    logic signed [ALT_W-1:0] alt;
  } side_t;

  typedef struct packed {
    logic signed [LW-1:0] px;
    logic signed [LW-1:0] py;
    logic signed [LW-1:0] pz;
  } pos_t;

  typedef struct packed {
    logic valid;
    logic ovalid;
  } flag_t;

  // Product scaled back by the fraction bits, rounded half away from zero.
  function automatic logic signed [LW-1:0] mulq(input logic signed [LW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic [LW-1:0]    ua;
    logic [CW-1:0]    ub;
    logic [LW+CW-1:0] prod;
    logic [LW+CW-1:0] rnd;
    logic [LW-1:0]    mag;
    ua = a[LW-1] ? LW'(-a) : LW'(a);
    ub = b[CW-1] ? CW'(-b) : CW'(b);
    prod = (LW+CW)'(ua) * (LW+CW)'(ub);
    rnd = prod + ((LW+CW)'(1) << (FRAC - 1));
    mag = LW'(rnd >> FRAC);
    return (a[LW-1] ^ b[CW-1]) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [SW-1:0] v,
                                               input int w);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = (SW'(1) <<< (w - 1)) - SW'(1);
    lo = -hi - SW'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

@@ rtl/g2n_cordic_cell.sv @@
module g2n_cordic_cell import g2n_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [STG_W-1:0] stage,
  input  cordic_t          c_in,
  output cordic_t          c_out
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] atn;
  cordic_t              c_nxt;

  always_comb begin
    dx = c_in.y >>> stage;
    dy = c_in.x >>> stage;
    atn = ZW'(ATAN_TAB[stage]);
    c_nxt.flip = c_in.flip;
    if (!c_in.z[ZW-1]) begin
      c_nxt.x = c_in.x - dx;
      c_nxt.y = c_in.y + dy;
      c_nxt.z = c_in.z - atn;
    end else begin
      c_nxt.x = c_in.x + dx;
      c_nxt.y = c_in.y - dy;
      c_nxt.z = c_in.z + atn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_out <= c_nxt;
    end
  end

endmodule

@@ rtl/g2n_sqrt_cell.sv @@
module g2n_sqrt_cell import g2n_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SQ_PW-1:0] pos,
  input  sqrt_t            s_in,
  output sqrt_t            s_out
);

  logic [SQ_VW-1:0] sh;
  logic [SQ_RW-1:0] rr;
  logic [SQ_RW-1:0] t;
  logic             ge;
  sqrt_t            s_nxt;

  always_comb begin
    sh = s_in.v >> {pos, 1'b0};
    rr = {s_in.r[SQ_RW-3:0], sh[1:0]};
    t = {s_in.q, 2'b01};
    ge = (rr >= t);
    s_nxt.v = s_in.v;
    s_nxt.r = ge ? rr - t : rr;
    s_nxt.q = {s_in.q[SQ_QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_out <= s_nxt;
    end
  end

endmodule

@@ rtl/g2n_div_cell.sv @@
module g2n_div_cell import g2n_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_KW-1:0] bitpos,
  input  div_t              d_in,
  output div_t              d_out
);

  logic [DIV_RW-1:0] rs;
  logic [DIV_RW-1:0] qx;
  logic              ge;
  div_t              d_nxt;

  always_comb begin
    rs = {d_in.r[DIV_RW-2:0], DIVIDEND[bitpos]};
    qx = {1'b0, d_in.q};
    ge = (rs >= qx);
    d_nxt.q = d_in.q;
    d_nxt.r = ge ? rs - qx : rs;
    d_nxt.quo = {d_in.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_nxt;
    end
  end

endmodule

@@ rtl/g2n_geo_path.sv @@
module g2n_geo_path import g2n_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] lat,
  input  logic signed [ANG_W-1:0] lon,
  input  logic signed [ALT_W-1:0] alt,
  output pos_t                    ecef,
  output trig_t                   trig
);

  cordic_t lat_c [0:CORDIC_STAGES];
  cordic_t lon_c [0:CORDIC_STAGES];
  logic signed [ALT_W-1:0] alt_r [0:CORDIC_STAGES-1];
  side_t   side_r [0:SIDE_DEPTH-1];
  side_t   side_e1_r;
  trig_t   trig_a;
  logic signed [LW-1:0] ss_r;
  logic signed [LW-1:0] dd;
  logic [FRAC:0] d_r;
  sqrt_t   sq [0:SQRT_CELLS];
  div_t    dv [0:DIV_CELLS];
  logic signed [LW-1:0] n_r;
  logic signed [LW-1:0] hc_r;
  logic signed [LW-1:0] mz_r;
  logic    rnd;

  function automatic cordic_t fold(input logic signed [ANG_W-1:0] ang);
    cordic_t c;
    logic signed [ZW-1:0] za;
    za = ZW'(ang);
    c.x = CW'(GAIN);
    c.y = '0;
    c.z = za;
    c.flip = 1'b0;
    if (za > QUARTER_TURN) begin
      c.z = za - HALF_TURN;
      c.flip = 1'b1;
    end else if (za < -QUARTER_TURN) begin
      c.z = za + HALF_TURN;
      c.flip = 1'b1;
    end
    return c;
  endfunction

  assign lat_c[0] = fold(lat);
  assign lon_c[0] = fold(lon);

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    g2n_cordic_cell u_lat (
      .clk(clk), .en(en), .stage(STG_W'(i)), .c_in(lat_c[i]), .c_out(lat_c[i+1])
    );
    g2n_cordic_cell u_lon (
      .clk(clk), .en(en), .stage(STG_W'(i)), .c_in(lon_c[i]), .c_out(lon_c[i+1])
    );
  end

  always_comb begin
    trig_a.sl = lat_c[CORDIC_STAGES].flip ? -lat_c[CORDIC_STAGES].y : lat_c[CORDIC_STAGES].y;
    trig_a.cl = lat_c[CORDIC_STAGES].flip ? -lat_c[CORDIC_STAGES].x : lat_c[CORDIC_STAGES].x;
    trig_a.so = lon_c[CORDIC_STAGES].flip ? -lon_c[CORDIC_STAGES].y : lon_c[CORDIC_STAGES].y;
    trig_a.co = lon_c[CORDIC_STAGES].flip ? -lon_c[CORDIC_STAGES].x : lon_c[CORDIC_STAGES].x;
    dd = LW'(ONE) - mulq(ss_r, CW'(E2));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alt_r[0] <= alt;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
        alt_r[i] <= alt_r[i-1];
      end
      side_r[0] <= '{trig: trig_a, alt: alt_r[CORDIC_STAGES-1]};
      for (int i = 1; i < SIDE_DEPTH; i++) begin
        side_r[i] <= side_r[i-1];
      end
      ss_r <= mulq(LW'(side_r[0].trig.sl), side_r[0].trig.sl);
      d_r <= (dd < LW'(1)) ? (FRAC+1)'(1) : dd[FRAC:0];
    end
  end

  assign sq[0] = '{r: '0, q: '0, v: {1'b0, d_r, FRAC'(0)}};

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    g2n_sqrt_cell u_cell (
      .clk(clk), .en(en), .pos(SQ_PW'(FRAC - j)), .s_in(sq[j]), .s_out(sq[j+1])
    );
  end

  assign dv[0] = '{r: '0, q: sq[SQRT_CELLS].q[DIV_QW-1:0], quo: '0};

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    g2n_div_cell u_cell (
      .clk(clk), .en(en), .bitpos(DIV_KW'(DIV_CELLS - 1 - j)), .d_in(dv[j]),
      .d_out(dv[j+1])
    );
  end

  assign rnd = ({dv[DIV_CELLS].r, 1'b0} >= {2'b00, dv[DIV_CELLS].q});

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= LW'(dv[DIV_CELLS].quo) + LW'(rnd);
      hc_r <= mulq(n_r + LW'(side_r[SIDE_DEPTH-1].alt), side_r[SIDE_DEPTH-1].trig.cl);
      mz_r <= mulq(n_r, CW'(ONE_M_E2)) + LW'(side_r[SIDE_DEPTH-1].alt);
      side_e1_r <= side_r[SIDE_DEPTH-1];
      ecef.px <= mulq(hc_r, side_e1_r.trig.co);
      ecef.py <= mulq(hc_r, side_e1_r.trig.so);
      ecef.pz <= mulq(mz_r, side_e1_r.trig.sl);
      trig <= side_e1_r.trig;
    end
  end

endmodule

@@ rtl/geodetic_to_ned_converter.sv @@
// Converts a geodetic position (latitude, longitude, altitude) to WGS84
// Earth-centered coordinates and to north, east and down offsets from a
// configured origin.
// Input takes one word per cycle on in_tvalid/in_tready unless stalled.
// Each result word leaves on the out_ channel with out_tuser as status:
// zero when converted, one when the origin is not marked valid, in which
// case all coordinates are zero.
// Origin registers are written through the cfg_ channel, which is always
// ready; they are to be written only while no word is in flight.
// Each word passes the 24 CORDIC cells, the 31 square-root cells and the
// 63 division cells of the radius chain, and one word per cycle is
// sustained while the receiver takes results.
// The origin runs through its own copy of the chain next to each word.
// When the receiver stalls with a result pending, the whole pipeline
// holds and in_tready falls; no word is lost.
// Reset clears the origin registers, the origin valid flag and all
// pipeline valid bits.
module geodetic_to_ned_converter import g2n_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [95:0]       in_tdata,   // lat[31:0], lon[63:32], alt[91:64]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [207:0]      out_tdata,  // ecef_x, ecef_y, ecef_z, north, east, down
  output logic              out_tuser,  // status
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);

  logic                    en;
  logic signed [ANG_W-1:0] olat_r;
  logic signed [ANG_W-1:0] olon_r;
  logic signed [ALT_W-1:0] oalt_r;
  logic                    ovalid_r;
  pos_t                    pos_e;
  pos_t                    org_e;
  trig_t                   pos_t_unused;
  trig_t                   ot;
  flag_t                   flag_r [0:GEO_LAT+1];
  logic signed [LW-1:0]    dx_r;
  logic signed [LW-1:0]    dy_r;
  logic signed [LW-1:0]    dz_r;
  logic signed [CW-1:0]    r00_r, r01_r, r02_r, r10_r, r11_r, r20_r, r21_r, r22_r;
  pos_t                    e1_r;
  pos_t                    e2_r;
  logic signed [LW-1:0]    m00_r, m01_r, m02_r, m10_r, m11_r, m20_r, m21_r, m22_r;
  logic signed [SW-1:0]    nn;
  logic signed [SW-1:0]    ee;
  logic signed [SW-1:0]    dn;
  logic signed [SW-1:0]    sx;
  logic signed [SW-1:0]    sy;
  logic signed [SW-1:0]    sz;
  logic signed [SW-1:0]    snn;
  logic signed [SW-1:0]    see;
  logic signed [SW-1:0]    sdn;
  logic [207:0]            data_nxt;
  logic                    out_valid_r;
  logic [207:0]            out_data_r;
  logic                    out_user_r;

  assign en = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      olat_r <= '0;
      olon_r <= '0;
      oalt_r <= '0;
      ovalid_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_LAT:   olat_r <= cfg_data;
        REG_ORIGIN_LON:   olon_r <= cfg_data;
        REG_ORIGIN_ALT:   oalt_r <= cfg_data[ALT_W-1:0];
        REG_ORIGIN_VALID: ovalid_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  g2n_geo_path u_pos (
    .clk(clk), .en(en), .lat(in_tdata[31:0]), .lon(in_tdata[63:32]),
    .alt(in_tdata[91:64]), .ecef(pos_e), .trig(pos_t_unused)
  );

  g2n_geo_path u_org (
    .clk(clk), .en(en), .lat(olat_r), .lon(olon_r), .alt(oalt_r),
    .ecef(org_e), .trig(ot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GEO_LAT + 2; i++) begin
        flag_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      flag_r[0] <= '{valid: in_tvalid, ovalid: ovalid_r};
      for (int i = 1; i < GEO_LAT + 2; i++) begin
        flag_r[i] <= flag_r[i-1];
      end
      out_valid_r <= flag_r[GEO_LAT+1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= pos_e.px - org_e.px;
      dy_r <= pos_e.py - org_e.py;
      dz_r <= pos_e.pz - org_e.pz;
      r00_r <= -CW'(mulq(LW'(ot.sl), ot.co));
      r01_r <= -CW'(mulq(LW'(ot.sl), ot.so));
      r02_r <= ot.cl;
      r10_r <= -ot.so;
      r11_r <= ot.co;
      r20_r <= -CW'(mulq(LW'(ot.cl), ot.co));
      r21_r <= -CW'(mulq(LW'(ot.cl), ot.so));
      r22_r <= -ot.sl;
      e1_r <= pos_e;
      m00_r <= mulq(dx_r, r00_r);
      m01_r <= mulq(dy_r, r01_r);
      m02_r <= mulq(dz_r, r02_r);
      m10_r <= mulq(dx_r, r10_r);
      m11_r <= mulq(dy_r, r11_r);
      m20_r <= mulq(dx_r, r20_r);
      m21_r <= mulq(dy_r, r21_r);
      m22_r <= mulq(dz_r, r22_r);
      e2_r <= e1_r;
      out_data_r <= data_nxt;
      out_user_r <= !flag_r[GEO_LAT+1].ovalid;
    end
  end

  always_comb begin
    nn = SW'(m00_r) + SW'(m01_r) + SW'(m02_r);
    ee = SW'(m10_r) + SW'(m11_r);
    dn = SW'(m20_r) + SW'(m21_r) + SW'(m22_r);
    sx = sat(SW'(e2_r.px), ECEF_W);
    sy = sat(SW'(e2_r.py), ECEF_W);
    sz = sat(SW'(e2_r.pz), ECEF_W);
    snn = sat(nn, NED_W);
    see = sat(ee, NED_W);
    sdn = sat(dn, NED_W);
    data_nxt = '0;
    if (flag_r[GEO_LAT+1].ovalid) begin
      data_nxt[33:0]    = sx[ECEF_W-1:0];
      data_nxt[67:34]   = sy[ECEF_W-1:0];
      data_nxt[101:68]  = sz[ECEF_W-1:0];
      data_nxt[136:102] = snn[NED_W-1:0];
      data_nxt[171:137] = see[NED_W-1:0];
      data_nxt[206:172] = sdn[NED_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

@@ dv/geodetic_to_ned_converter_test.sv @@
`timescale 1ns / 1ps

module geodetic_to_ned_converter_test;
  import g2n_pkg::*;

  localparam logic [CFG_IW-1:0] REG_UNUSED = CFG_IW'(9);
  localparam longint CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 180;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [CFG_IW-1:0] index;
    logic [31:0]       lat;
    logic [31:0]       lon;
    logic [27:0]       alt;
    bit                typed;
  } row_t;

  typedef struct packed {
    logic        status;
    logic [33:0] ex;
    logic [33:0] ey;
    logic [33:0] ez;
    logic [34:0] north;
    logic [34:0] east;
    logic [34:0] down;
  } fix_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [95:0]       in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [207:0]      out_tdata;
  logic              out_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0]       cfg_data = '0;

  logic [31:0] org_lat = '0;
  logic [31:0] org_lon = '0;
  logic [27:0] org_alt = '0;
  logic        org_valid = 1'b0;

  fix_t   fix_expect_q[$];
  int     errors = 0;
  int     words_sent = 0;
  int     origins_used = 0;
  longint cycles = 0;
  bit     calm = 1'b0;
  logic   stall_go = 1'b0;
  int     hold_left = 0;

  geodetic_to_ned_converter uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] ua, ub, pr;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = {64'd0, (a < 0) ? (64'd0 - 64'(a)) : 64'(a)};
    ub = {64'd0, (b < 0) ? (64'd0 - 64'(b)) : 64'(b)};
    pr = ((ua * ub) + (128'd1 << (FRAC - 1))) >> FRAC;
    if (pr > 128'h7FFF_FFFF_FFFF_FFFF) pr = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -$signed(pr[63:0]) : $signed(pr[63:0]);
  endfunction

  function automatic void trig(longint ang, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    bit flip;
    x = (GAIN_Q40 + (64'sd1 <<< (39 - FRAC))) >>> (40 - FRAC);
    y = 0;
    z = ang;
    flip = 1'b0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < ANGLE_TABLE_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint radius_mm(longint d);
    logic [127:0] v, r, q, t, num, quo, rem;
    v = 128'(d) << FRAC;
    r = '0;
    q = '0;
    for (int p = FRAC; p >= 0; p--) begin
      r = (r << 2) | ((v >> (2 * p)) & 128'd3);
      t = (q << 2) | 128'd1;
      if (r >= t) begin
        r -= t;
        q = (q << 1) | 128'd1;
      end else begin
        q = q << 1;
      end
    end
    if (q == 0) q = 1;
    num = 128'(SEMI_MAJOR_MM) << FRAC;
    quo = num / q;
    rem = num % q;
    if (2 * rem >= q) quo++;
    return longint'(quo[46:0]);
  endfunction

  function automatic void geo_to_ecef(longint sl, longint cl, longint so, longint co,
                                      longint alt, output longint px, output longint py,
                                      output longint pz);
    longint one, e2, d, n, hc;
    one = 64'sd1 <<< FRAC;
    e2 = (ECC2_Q40 + (64'sd1 <<< (39 - FRAC))) >>> (40 - FRAC);
    d = one - fx_mul(e2, fx_mul(sl, sl));
    if (d < 1) d = 1;
    n = radius_mm(d);
    hc = fx_mul(n + alt, cl);
    px = fx_mul(hc, co);
    py = fx_mul(hc, so);
    pz = fx_mul(fx_mul(n, one - e2) + alt, sl);
  endfunction

  function automatic logic [34:0] clip(longint v, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return 35'(v) & ((35'd1 << w) - 35'd1);
  endfunction

  function automatic fix_t predict_ned(logic [31:0] lat, logic [31:0] lon, logic [27:0] alt);
    fix_t f;
    longint sl, cl, so, co, osl, ocl, oso, oco;
    longint px, py, pz, ox, oy, oz, dx, dy, dz, nn, ee, dd;
    f = '0;
    if (!org_valid) begin
      f.status = 1'b1;
      return f;
    end
    trig(longint'($signed(lat)), sl, cl);
    trig(longint'($signed(lon)), so, co);
    geo_to_ecef(sl, cl, so, co, longint'($signed(alt)), px, py, pz);
    trig(longint'($signed(org_lat)), osl, ocl);
    trig(longint'($signed(org_lon)), oso, oco);
    geo_to_ecef(osl, ocl, oso, oco, longint'($signed(org_alt)), ox, oy, oz);
    dx = px - ox;
    dy = py - oy;
    dz = pz - oz;
    nn = fx_mul(-fx_mul(osl, oco), dx) + fx_mul(-fx_mul(osl, oso), dy) + fx_mul(ocl, dz);
    ee = fx_mul(-oso, dx) + fx_mul(oco, dy);
    dd = fx_mul(-fx_mul(ocl, oco), dx) + fx_mul(-fx_mul(ocl, oso), dy) + fx_mul(-osl, dz);
    f.ex = 34'(clip(px, ECEF_W));
    f.ey = 34'(clip(py, ECEF_W));
    f.ez = 34'(clip(pz, ECEF_W));
    f.north = clip(nn, NED_W);
    f.east = clip(ee, NED_W);
    f.down = clip(dd, NED_W);
    return f;
  endfunction

  task automatic report_mismatch(string field, logic [34:0] got, logic [34:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, field, got, want);
  endtask

  always @(posedge clk) begin
    if (stall_go && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    fix_t w, g;
    out_tready <= !stall_go && hold_left <= 1 && (calm || $urandom_range(99) >= 33);
    if (rst_n && out_tvalid && out_tready) begin
      g.status = out_tuser;
      g.ex = out_tdata[33:0];
      g.ey = out_tdata[67:34];
      g.ez = out_tdata[101:68];
      g.north = out_tdata[136:102];
      g.east = out_tdata[171:137];
      g.down = out_tdata[206:172];
      if (fix_expect_q.size() == 0) begin
        report_mismatch("unexpected word", {34'd0, g.status}, '0);
      end else begin
        w = fix_expect_q.pop_front();
        if (g.status != w.status) report_mismatch("status", 35'(g.status), 35'(w.status));
        if (g.ex != w.ex) report_mismatch("ecef_x", 35'(g.ex), 35'(w.ex));
        if (g.ey != w.ey) report_mismatch("ecef_y", 35'(g.ey), 35'(w.ey));
        if (g.ez != w.ez) report_mismatch("ecef_z", 35'(g.ez), 35'(w.ez));
        if (g.north != w.north) report_mismatch("north", g.north, w.north);
        if (g.east != w.east) report_mismatch("east", g.east, w.east);
        if (g.down != w.down) report_mismatch("down", g.down, w.down);
      end
    end
  end

  task automatic send_word(logic [31:0] lat, logic [31:0] lon, logic [27:0] alt,
                           bit typed, fix_t typed_fix);
    while (!calm && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, alt, lon, lat};
    do @(posedge clk); while (!in_tready);
    fix_expect_q.push_back(typed ? typed_fix : predict_ned(lat, lon, alt));
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (fix_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] index, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_ORIGIN_LAT: org_lat = data;
      REG_ORIGIN_LON: org_lon = data;
      REG_ORIGIN_ALT: org_alt = data[27:0];
      REG_ORIGIN_VALID: org_valid = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_lat();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'(longint'($urandom_range(32'h8000_0000)) - 64'sd1073741824);
  endfunction

  function automatic logic [27:0] rand_alt();
    if ($urandom_range(9) == 0) return 28'($urandom);
    return 28'(longint'($urandom_range(101000000)) - 64'sd1000000);
  endfunction

  row_t rows[] = '{
    '{ROW_WORD, '0, 32'd0, 32'd0, 28'd0, 1'b1},
    '{ROW_WORD, '0, 32'h4000_0000, 32'h7FFF_FFFF, 28'h5F5_E100, 1'b1},
    '{ROW_WORD, '0, 32'hC000_0000, 32'h8000_0000, 28'hFF0_BDC0, 1'b1},
    '{ROW_CFG, REG_ORIGIN_VALID, 32'd1, 32'd0, 28'd0, 1'b0},
    '{ROW_WORD, '0, 32'd0, 32'd0, 28'd0, 1'b0},
    '{ROW_WORD, '0, 32'h4000_0000, 32'd0, 28'd0, 1'b0},
    '{ROW_WORD, '0, 32'hC000_0000, 32'd0, 28'd0, 1'b0},
    '{ROW_WORD, '0, 32'h7FFF_FFFF, 32'h4000_0000, 28'd0, 1'b0},
    '{ROW_WORD, '0, 32'h8000_0000, 32'hC000_0000, 28'd0, 1'b0},
    '{ROW_WORD, '0, 32'h1234_5678, 32'h7FFF_FFFF, 28'h5F5_E100, 1'b0},
    '{ROW_WORD, '0, 32'hEDCB_A988, 32'h8000_0000, 28'hFF0_BDC0, 1'b0},
    '{ROW_WORD, '0, 32'h2000_0000, 32'h6000_0000, 28'h7FF_FFFF, 1'b0},
    '{ROW_WORD, '0, 32'hE000_0000, 32'hA000_0000, 28'h800_0000, 1'b0},
    '{ROW_CFG, REG_ORIGIN_LAT, 32'h4000_0000, 32'd0, 28'd0, 1'b0},
    '{ROW_CFG, REG_ORIGIN_LON, 32'h8000_0000, 32'd0, 28'd0, 1'b0},
    '{ROW_CFG, REG_ORIGIN_ALT, 32'hFFF0_BDC0, 32'd0, 28'd0, 1'b0},
    '{ROW_CFG, REG_UNUSED, 32'hFFFF_FFFF, 32'd0, 28'd0, 1'b0},
    '{ROW_WORD, '0, 32'h4000_0000, 32'h8000_0000, 28'hFF0_BDC0, 1'b0},
    '{ROW_WORD, '0, 32'h3FFF_0000, 32'h8000_1000, 28'd1000, 1'b0},
    '{ROW_WORD, '0, 32'hC000_0000, 32'h7FFF_FFFF, 28'h5F5_E100, 1'b0},
    '{ROW_CFG, REG_ORIGIN_VALID, 32'hFFFF_FFFE, 32'd0, 28'd0, 1'b0},
    '{ROW_WORD, '0, 32'h1000_0000, 32'h1000_0000, 28'd5000, 1'b1}
  };

  initial begin
    fix_t no_origin;
    logic [31:0] lat, lon;
    no_origin = '0;
    no_origin.status = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(rows[i].index, rows[i].lat);
        origins_used++;
      end else begin
        send_word(rows[i].lat, rows[i].lon, rows[i].alt, rows[i].typed, no_origin);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      calm = (ph == 3);
      case (ph)
        0: begin
          write_reg(REG_ORIGIN_LAT, 32'h4000_0000);
          write_reg(REG_ORIGIN_LON, 32'h7FFF_FFFF);
          write_reg(REG_ORIGIN_ALT, 32'h05F5_E100);
        end
        1: begin
          write_reg(REG_ORIGIN_LAT, 32'hC000_0000);
          write_reg(REG_ORIGIN_LON, 32'h8000_0000);
          write_reg(REG_ORIGIN_ALT, 32'hFFF0_BDC0);
        end
        default: begin
          write_reg(REG_ORIGIN_LAT, rand_lat());
          write_reg(REG_ORIGIN_LON, $urandom);
          write_reg(REG_ORIGIN_ALT, {4'($urandom_range(15)), rand_alt()});
        end
      endcase
      write_reg(CFG_IW'($urandom_range(15, 4)), $urandom);
      write_reg(REG_ORIGIN_VALID, (ph == 2) ? ($urandom & 32'hFFFF_FFFE) : ($urandom | 32'd1));
      origins_used++;
      if (ph == 1) begin
        stall_go <= 1'b1;
        @(posedge clk);
        stall_go <= 1'b0;
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if ($urandom_range(4) == 0) begin
          lat = org_lat + 32'($urandom_range(20000)) - 32'd10000;
          lon = org_lon + 32'($urandom_range(20000)) - 32'd10000;
        end else begin
          lat = rand_lat();
          lon = $urandom;
        end
        send_word(lat, lon, rand_alt(), 1'b0, no_origin);
      end
    end

    drain();
    calm = 1'b0;
    repeat (GEO_LAT + 30) @(posedge clk);
    $display("Ran %0d words through %0d origin settings, including pole and date-line",
             words_sent, origins_used);
    $display("extremes, an unset origin, random stalls and one long receiver hold-off.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
